FILE: rtl/skf_pkg.sv
package skf_pkg;

  localparam int CHANNELS  = 64;
  localparam int FRAC_BITS = 6;
  localparam int INTEGER_BITS = 13;

  localparam int WORD_W    = INTEGER_BITS + FRAC_BITS;
  localparam int DEN_W     = WORD_W + 1;
  localparam int DVD_W     = WORD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int CH_W      = 6;
  localparam int CH_IDX_W  = $clog2(CHANNELS);
  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_OFFSET = 2'd2;

  localparam logic [REG_W-1:0] INIT_VAR_RST   = REG_W'(32);
  localparam logic [REG_W-1:0] PROC_NOISE_RST = REG_W'(1);
  localparam logic [REG_W-1:0] DEN_OFFSET_RST = REG_W'(65);

endpackage

FILE: rtl/skf_in_if.sv
interface skf_in_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel;
  logic signed [WORD_W-1:0] sample;
  logic                     first_sample;

  modport source (output valid, channel, sample, first_sample, input ready);
  modport sink (input valid, channel, sample, first_sample, output ready);

endinterface

FILE: rtl/skf_out_if.sv
interface skf_out_if;
  import skf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          out_channel;
  logic signed [WORD_W-1:0] estimate;

  modport source (output valid, out_channel, estimate, input ready);
  modport sink (input valid, out_channel, estimate, output ready);

endinterface

FILE: rtl/skf_ram.sv
module skf_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/scalar_kalman_filter_multichannel_core.sv
// Multichannel scalar Kalman filter, one filter per channel, on signed 19-bit
// fixed-point samples with 6 fraction bits. Each item with first_sample set
// restarts its channel and returns the sample itself through writeback; any
// other item runs a full update through the read, prepare, divide, gain fix,
// two multiply and writeback states. The update time is set by the gain
// division, a radix-2 restoring divider that resolves one quotient bit per
// cycle, followed by two products on one shared multiplier. One item is in
// work at a time, so a new item is taken only after the last one has left
// writeback; in_ch.ready is high only while the sequencer is idle, and the
// result waits in an output register until taken, which stalls the next
// item. Per-channel estimate and variance live in two small RAMs whose
// contents are undefined until a first sample writes the channel. Write
// configuration only while no item is in work.
module scalar_kalman_filter_multichannel_core (
  input  logic                           clk,
  input  logic                           rst_n,
  skf_in_if.sink                         in_ch,
  skf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [skf_pkg::REG_W-1:0]      cfg_data
);
  import skf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_PREP = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_KFIX = 8'b0001_0000,
    S_MUL1 = 8'b0010_0000,
    S_MUL2 = 8'b0100_0000,
    S_WB   = 8'b1000_0000
  } state_t;

  localparam logic signed [DEN_W-1:0] ONE_VAL  = DEN_W'(2 ** FRAC_BITS);
  localparam logic [DVD_W-1:0]        HALF_LSB = DVD_W'(2 ** (FRAC_BITS - 1));

  state_t state_r, state_nxt;

  logic [REG_W-1:0] init_var_r;
  logic [REG_W-1:0] proc_noise_r;
  logic [REG_W-1:0] den_offset_r;

  logic [CH_W-1:0]          ch_r;
  logic [CH_IDX_W-1:0]      idx_r;
  logic signed [WORD_W-1:0] smp_r;
  logic                     first_r;
  logic signed [WORD_W-1:0] e_r;
  logic signed [WORD_W-1:0] c_r;
  logic signed [DEN_W-1:0]  diff_r;
  logic [WORD_W-1:0]        dvs_r;
  logic [DVD_W-1:0]         quo_r;
  logic [WORD_W-1:0]        rem_r;
  logic                     neg_r;
  logic                     dz_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic signed [WORD_W-1:0] k_r;
  logic [DVD_W-1:0]         prod_r;

  logic                     out_valid_r;
  logic [CH_W-1:0]          out_channel_r;
  logic signed [WORD_W-1:0] out_estimate_r;

  logic [WORD_W-1:0] est_rdata;
  logic [WORD_W-1:0] var_rdata;
  logic [WORD_W-1:0] var_wdata;

  logic                       in_acc;
  logic                       wb_go;
  logic signed [WORD_W-1:0]   p_w;
  logic signed [WORD_W-1:0]   e_w;
  logic signed [WORD_W-1:0]   c_w;
  logic signed [DEN_W-1:0]    den_w;
  logic [DEN_W-1:0]           den_abs;
  logic [DVD_W-1:0]           dvd_w;
  logic [DVD_W-1:0]           dvd_abs;
  logic [WORD_W:0]            rem_sh;
  logic [WORD_W:0]            rem_sub;
  logic                       q_bit;
  logic [DVD_W-1:0]           quo_s;
  logic signed [DEN_W-1:0]    mul_a;
  logic signed [DEN_W-1:0]    mul_b;
  logic signed [2*DEN_W-1:0]  mul_p;
  logic [DVD_W-1:0]           esum_w;
  logic [DVD_W-1:0]           psum_w;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wb_go       = (state_r == S_WB) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_channel_r;
  assign out_ch.estimate    = out_estimate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_var_r   <= INIT_VAR_RST;
      proc_noise_r <= PROC_NOISE_RST;
      den_offset_r <= DEN_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INIT_VAR:   init_var_r   <= cfg_data;
        REG_PROC_NOISE: proc_noise_r <= cfg_data;
        REG_DEN_OFFSET: den_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update of the prior variance
  assign p_w     = $signed(var_rdata);
  assign e_w     = $signed(est_rdata);
  assign c_w     = p_w + $signed({{(WORD_W-REG_W){1'b0}}, proc_noise_r});
  assign den_w   = {p_w[WORD_W-1], p_w} + $signed({{(DEN_W-REG_W){1'b0}}, den_offset_r});
  assign den_abs = den_w[DEN_W-1] ? DEN_W'(-den_w) : DEN_W'(den_w);
  assign dvd_w   = {c_w, {FRAC_BITS{1'b0}}};
  assign dvd_abs = dvd_w[DVD_W-1] ? -dvd_w : dvd_w;

  // restoring divider step
  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign q_bit   = ~rem_sub[WORD_W];
  assign quo_s   = neg_r ? -quo_r : quo_r;

  // shared multiplier
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {k_r[WORD_W-1], k_r};
      mul_b = diff_r;
    end else begin
      mul_a = ONE_VAL - {k_r[WORD_W-1], k_r};
      mul_b = {c_r[WORD_W-1], c_r};
    end
  end
  assign mul_p = mul_a * mul_b;

  assign esum_w    = {e_r, {FRAC_BITS{1'b0}}} + prod_r + HALF_LSB;
  assign psum_w    = prod_r + HALF_LSB;
  assign var_wdata = first_r ? {{(WORD_W-REG_W){1'b0}}, init_var_r}
                             : psum_w[DVD_W-1:FRAC_BITS];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ch.first_sample ? S_WB : S_RD;
        end
      end
      S_RD:   state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_KFIX;
        end
      end
      S_KFIX: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_WB;
      S_WB: begin
        if (wb_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r    <= in_ch.channel;
      idx_r   <= in_ch.channel[CH_IDX_W-1:0];
      smp_r   <= in_ch.sample;
      first_r <= in_ch.first_sample;
      e_r     <= in_ch.sample;
    end
    if (state_r == S_PREP) begin
      e_r    <= e_w;
      c_r    <= c_w;
      diff_r <= {smp_r[WORD_W-1], smp_r} - {e_w[WORD_W-1], e_w};
      dvs_r  <= den_abs[WORD_W-1:0];
      quo_r  <= dvd_abs;
      rem_r  <= '0;
      neg_r  <= c_w[WORD_W-1] ^ den_w[DEN_W-1];
      dz_r   <= (den_w == '0);
      cnt_r  <= DIV_CNT_W'(DVD_W - 1);
    end
    if (state_r == S_DIV) begin
      quo_r <= {quo_r[DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
    if (state_r == S_KFIX) begin
      k_r <= dz_r ? '0 : $signed(quo_s[WORD_W-1:0]);
    end
    if (state_r == S_MUL1 || state_r == S_MUL2) begin
      prod_r <= mul_p[DVD_W-1:0];
    end
    if (state_r == S_MUL2) begin
      e_r <= $signed(esum_w[DVD_W-1:FRAC_BITS]);
    end
    if (wb_go) begin
      out_channel_r  <= ch_r;
      out_estimate_r <= e_r;
    end
  end

  skf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_est_ram (
    .clk   (clk),
    .we    (wb_go),
    .waddr (idx_r),
    .wdata (e_r),
    .raddr (idx_r),
    .rdata (est_rdata)
  );

  skf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_var_ram (
    .clk   (clk),
    .we    (wb_go),
    .waddr (idx_r),
    .wdata (var_wdata),
    .raddr (idx_r),
    .rdata (var_rdata)
  );

  a_update_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.first_sample) |=> (state_r == S_RD))
    else $error("update item did not start a store read");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> ##(DVD_W+1) (state_r == S_KFIX))
    else $error("gain division did not take the full bit count");

  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KFIX && dz_r) |=> (k_r == '0))
    else $error("zero divisor gave a nonzero gain");

  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result raised outside writeback");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import skf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASE_ITEMS = 270;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [REG_W-1:0] REG_MAX = '1;
  localparam longint UNITY = longint'(1) << FRAC_BITS;
  localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
  localparam longint WORD_MAX = (longint'(1) << (WORD_W - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  typedef struct {
    logic [CH_W-1:0]          channel;
    logic signed [WORD_W-1:0] sample;
    logic                     first_sample;
  } sample_item_t;

  typedef struct {
    logic [CH_W-1:0]          channel;
    logic signed [WORD_W-1:0] estimate;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_data;

  skf_in_if in_bus();
  skf_out_if out_bus();

  scalar_kalman_filter_multichannel_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  sample_item_t pending_items[$];
  estimate_t expected_estimates[$];

  logic signed [WORD_W-1:0] est_store [CHANNELS];
  logic signed [WORD_W-1:0] var_store [CHANNELS];
  logic [REG_W-1:0] init_var;
  logic [REG_W-1:0] proc_noise;
  logic [REG_W-1:0] den_offset;

  bit started [CHANNELS];
  longint level [CHANNELS];
  bit steady_flow;
  bit hold_pending;
  int hold_left;
  int mismatch_count;
  int cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint wrap_word(input longint x);
    logic signed [WORD_W-1:0] w;
    w = x[WORD_W-1:0];
    return longint'(w);
  endfunction

  function automatic longint round_word(input longint x);
    return wrap_word((x + HALF_LSB) >>> FRAC_BITS);
  endfunction

  function automatic estimate_t kalman_predict(input sample_item_t it);
    int idx;
    longint p, c, den, k, e, s;
    estimate_t res;
    idx = it.channel % CHANNELS;
    s = longint'(it.sample);
    if (it.first_sample) begin
      e = s;
      est_store[idx] = it.sample;
      var_store[idx] = WORD_W'(init_var);
    end else begin
      p = longint'(var_store[idx]);
      e = longint'(est_store[idx]);
      c = wrap_word(p + longint'(proc_noise));
      den = p + longint'(den_offset);
      k = 0;
      if (den != 0) begin
        k = wrap_word((c * UNITY) / den);
      end
      e = round_word(e * UNITY + k * (s - e));
      p = round_word((UNITY - k) * c);
      est_store[idx] = e[WORD_W-1:0];
      var_store[idx] = p[WORD_W-1:0];
    end
    res.channel = it.channel;
    res.estimate = e[WORD_W-1:0];
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input longint want,
                                          input longint seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what,
               want, seen);
    end
  endfunction

  always @(posedge clk) begin : drive_samples
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_estimates.push_back(kalman_predict(pending_items.pop_front()));
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (pending_items.size() != 0 && (steady_flow || $urandom_range(99) >= 20)) begin
          in_bus.valid <= 1'b1;
          in_bus.channel <= pending_items[0].channel;
          in_bus.sample <= pending_items[0].sample;
          in_bus.first_sample <= pending_items[0].first_sample;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_timer
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : check_estimates
    estimate_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("result with none pending, out_channel", longint'(-1),
                          longint'(out_bus.out_channel));
        end else begin
          want = expected_estimates.pop_front();
          if (out_bus.out_channel !== want.channel) begin
            report_mismatch("out_channel", longint'(want.channel),
                            longint'(out_bus.out_channel));
          end
          if (out_bus.estimate !== want.estimate) begin
            report_mismatch("estimate", longint'(want.estimate),
                            longint'(out_bus.estimate));
          end
        end
      end
      out_bus.ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[scalar_kalman_filter_multichannel_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INIT_VAR:   init_var = val;
      REG_PROC_NOISE: proc_noise = val;
      REG_DEN_OFFSET: den_offset = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [REG_W-1:0] iv, input logic [REG_W-1:0] q,
                              input logic [REG_W-1:0] d);
    write_reg(REG_INIT_VAR, iv);
    write_reg(REG_PROC_NOISE, q);
    write_reg(REG_DEN_OFFSET, d);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_estimates.size() != 0 || in_bus.valid) begin
      @(posedge clk);
    end
  endtask

  // a channel never started gets its first sample forced
  task automatic queue_item(input int ch, input longint smp, input bit first);
    sample_item_t it;
    it.channel = ch[CH_W-1:0];
    it.sample = smp[WORD_W-1:0];
    it.first_sample = first || !started[ch];
    started[ch] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic queue_random_items(input int count);
    int hot [4];
    int ch;
    int mode;
    bit first;
    longint smp;
    foreach (hot[i]) hot[i] = $urandom_range(CHANNELS - 1);
    repeat (count) begin
      ch = ($urandom_range(99) < 60) ? hot[$urandom_range(3)] : $urandom_range(CHANNELS - 1);
      first = !started[ch] || ($urandom_range(99) < 4);
      mode = $urandom_range(9);
      if (mode == 0) begin
        smp = longint'($urandom);
      end else if (mode == 1) begin
        case ($urandom_range(3))
          0: smp = WORD_MIN;
          1: smp = WORD_MAX;
          2: smp = 0;
          default: smp = -1;
        endcase
      end else begin
        if (first) level[ch] = longint'($urandom_range(65535)) - 32768;
        level[ch] += longint'($urandom_range(64)) - 32;
        smp = level[ch] + longint'($urandom_range(1023)) - 512;
      end
      queue_item(ch, smp, first);
    end
  endtask

  initial begin : run_test
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.channel = '0;
    in_bus.sample = '0;
    in_bus.first_sample = 1'b0;
    out_bus.ready = 1'b0;
    init_var = INIT_VAR_RST;
    proc_noise = PROC_NOISE_RST;
    den_offset = DEN_OFFSET_RST;
    steady_flow = 1'b0;
    hold_pending = 1'b0;
    hold_left = 0;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(0, WORD_MAX, 1'b1);
    queue_item(0, WORD_MIN, 1'b0);
    queue_item(0, WORD_MAX, 1'b0);
    queue_item(CHANNELS - 1, WORD_MIN, 1'b1);
    queue_item(CHANNELS - 1, WORD_MAX, 1'b0);
    queue_item(CHANNELS - 1, 0, 1'b0);
    queue_item(5, 0, 1'b1);
    queue_item(5, -1, 1'b0);
    queue_item(5, 1, 1'b0);
    queue_item(0, -1, 1'b1);
    queue_item(0, UNITY, 1'b0);
    wait_drained();

    // large noise, tiny offset: gain far above one, variance wraps
    write_config(REG_MAX, REG_MAX, 12'd1);
    queue_item(9, 1000, 1'b1);
    queue_item(9, WORD_MAX, 1'b0);
    queue_item(9, WORD_MIN, 1'b0);
    queue_item(9, 0, 1'b0);
    queue_item(9, -5000, 1'b0);
    wait_drained();

    // variance walks 0, -1, -2, then p + d hits zero on the third update
    write_config('0, 12'd3, 12'd2);
    write_reg(REG_UNUSED, REG_MAX);
    queue_item(7, 640, 1'b1);
    queue_item(7, 1280, 1'b0);
    queue_item(7, -1280, 1'b0);
    queue_item(7, 4000, 1'b0);
    queue_item(7, 100, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_config(REG_MAX, REG_MAX, REG_MAX);
        1: write_config('0, '0, 12'd1);
        2: begin
          write_config(REG_W'($urandom_range(4095)), REG_W'($urandom_range(4095)),
                       REG_W'($urandom_range(1, 4095)));
          steady_flow = 1'b1;
        end
        3: begin
          write_config(REG_W'($urandom_range(4095)), REG_W'($urandom_range(4095)),
                       REG_W'($urandom_range(1, 4095)));
          hold_pending = 1'b1;
        end
        4: write_config(INIT_VAR_RST, PROC_NOISE_RST, DEN_OFFSET_RST);
        default: write_config(REG_W'($urandom_range(4095)), REG_W'($urandom_range(4095)),
                              REG_W'($urandom_range(1, 64)));
      endcase
      queue_random_items(RANDOM_PHASE_ITEMS);
      wait_drained();
      steady_flow = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("[scalar_kalman_filter_multichannel_core] OK");
    end else begin
      $display("[scalar_kalman_filter_multichannel_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/skf_pkg.sv
rtl/skf_in_if.sv
rtl/skf_out_if.sv
rtl/skf_ram.sv
rtl/scalar_kalman_filter_multichannel_core.sv
test/testbench.sv
